FILE: hdl/slbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slbm_pkg;

    // Field widths fixed by the stream format
    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 10;
    localparam int PCT_W    = 7;
    localparam int LIT_W    = 5;
    localparam int COLOR_W  = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // Smoothing weight limits
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;

    // Exact floor(n/100) for n < 199728: (n * DIV100_MUL) >> DIV100_SHIFT
    localparam int PROD_W = 17;
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    localparam int DIV100_SHIFT = 24;
    localparam logic [PROD_W-1:0] DIV100_ROUND = 17'd99;

    // Color intensities
    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'd0;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    // Block result between the level filter and the color stage
    typedef struct packed {
        level_t level;
        level_t avg;
    } lvl_t;

    // Output record, lowest field last
    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [LIT_W-1:0]   lit;
        level_t             level;
        level_t             avg;
    } res_t;

    // Ramp table, 64-step band: (i*mul)/63, or base minus it if falling
    function automatic logic [63:0][COLOR_W-1:0] ramp_tbl(input int base, input int mul,
                                                         input bit falling);
        logic [63:0][COLOR_W-1:0] tbl;
        int v;
        for (int i = 0; i < 64; i++)
        begin
            v = (i * mul) / 63;
            tbl[i] = COLOR_W'(falling ? (base - v) : v);
        end
        return tbl;
    endfunction

    localparam logic [63:0][COLOR_W-1:0] RED_RAMP = ramp_tbl(0, 255, 1'b0);
    localparam logic [63:0][COLOR_W-1:0] GRN_HI   = ramp_tbl(255, 90, 1'b1);
    localparam logic [63:0][COLOR_W-1:0] GRN_LO   = ramp_tbl(165, 165, 1'b1);

endpackage

`default_nettype wire

FILE: hdl/sound_level_bar_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: sample
// m_*       out  m_tvalid/m_tready  m_tdata: block average, level, lit count, r, g, b
// cfg_*     in   cfg_we             cfg_wdata: smoothing percent (saturated to 100)
//
// One sample is taken per cycle while s_tready is high; every 2^AVERAGE_SHIFT
// samples give one result. m_tvalid rises once a block's last sample has passed
// the block-average register, update stages A and B and the output register.
// The level feedback runs through two stages, so a block enters them only after the
// previous one has left stage A; with AVERAGE_SHIFT = 0 the input is held up likewise.
// s_tready falls only for a block-closing sample while the average stage is held.
// Reset clears block sum, count, level and all valids; the percent returns to 10.

module sound_level_bar_meter #(
    parameter int LED_COUNT     = 16,
    parameter int AVERAGE_SHIFT = 5
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [9:0] sample
    input  wire [slbm_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [9:0] block_average, [19:10] smoothed_level, [24:20] lit_count,
    // [32:25] red, [40:33] green, [48:41] blue
    output logic [slbm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire                               cfg_we,
    input  wire [slbm_pkg::PCT_W-1:0]         cfg_wdata
);

    logic [slbm_pkg::PCT_W-1:0] pct_reg;

    logic              avg_valid;
    logic              avg_ready;
    slbm_pkg::level_t  avg;
    logic              lvl_valid;
    logic              lvl_ready;
    slbm_pkg::lvl_t    lvl;
    slbm_pkg::res_t    res;

    // Smoothing weight, saturated on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= slbm_pkg::PCT_RESET;
        end
        else if (cfg_we)
        begin
            pct_reg <= (cfg_wdata > slbm_pkg::PCT_MAX) ? slbm_pkg::PCT_MAX : cfg_wdata;
        end
    end

    slbm_accum #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[slbm_pkg::SAMPLE_W-1:0]),
        .out_valid (avg_valid),
        .out_ready (avg_ready),
        .out_avg   (avg)
    );

    slbm_ema u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .pct       (pct_reg),
        .in_valid  (avg_valid),
        .in_ready  (avg_ready),
        .in_avg    (avg),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_lvl   (lvl)
    );

    slbm_color #(
        .LED_COUNT (LED_COUNT)
    ) u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lvl_valid),
        .in_ready  (lvl_ready),
        .in_lvl    (lvl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {(slbm_pkg::OUT_TDATA_W - $bits(slbm_pkg::res_t))'(0), res};

endmodule

`default_nettype wire

FILE: hdl/slbm_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module slbm_accum #(
    parameter int AVERAGE_SHIFT = 5
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire slbm_pkg::sample_t in_sample,
    output logic                  out_valid,
    input  wire                   out_ready,
    output slbm_pkg::level_t      out_avg
);

    localparam int SUM_W = slbm_pkg::SAMPLE_W + AVERAGE_SHIFT;
    localparam int CNT_W = (AVERAGE_SHIFT > 0) ? AVERAGE_SHIFT : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVERAGE_SHIFT) - 1);

    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              vld_reg;
    slbm_pkg::level_t  avg_reg;

    logic [SUM_W-1:0]  sum_next;
    logic              last_slot;
    logic              in_xfer;
    logic              hold_free;

    assign sum_next  = sum_reg + SUM_W'(in_sample);
    assign last_slot = (cnt_reg == CNT_LAST);
    assign hold_free = !vld_reg || out_ready;

    // Samples inside a block always go in; the closing one needs room for its average
    assign in_ready = !last_slot || hold_free;
    assign in_xfer  = in_valid && in_ready;

    // Block sum, sample count and block-average register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && last_slot)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
                vld_reg <= 1'b1;
            end
            else
            begin
                if (in_xfer)
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (out_ready)
                begin
                    vld_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && last_slot)
        begin
            avg_reg <= slbm_pkg::LEVEL_W'(sum_next >> AVERAGE_SHIFT);
        end
    end

    assign out_valid = vld_reg;
    assign out_avg   = avg_reg;

    // A closing sample always leaves an average behind
    a_close_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_slot |=> vld_reg)
        else $error("closing sample did not load the block average");

endmodule

`default_nettype wire

FILE: hdl/slbm_ema.sv
`timescale 1ns / 1ps
`default_nettype none

module slbm_ema (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [slbm_pkg::PCT_W-1:0] pct,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire slbm_pkg::level_t    in_avg,
    output logic                     out_valid,
    input  wire                      out_ready,
    output slbm_pkg::lvl_t           out_lvl
);

    localparam int PW = slbm_pkg::PROD_W;
    localparam int FW = PW + 18;

    // Stage A: signed weighted difference, level state
    slbm_pkg::level_t  level_reg;
    logic              vld2_reg;
    logic              neg2_reg;
    logic [PW-1:0]     mag2_reg;
    slbm_pkg::level_t  avg2_reg;

    // Stage B: updated level
    logic              vld3_reg;
    slbm_pkg::lvl_t    lvl3_reg;

    logic              neg_a;
    slbm_pkg::level_t  diff_a;
    logic [PW-1:0]     prod_a;
    logic [PW-1:0]     mag_a;
    logic              in_xfer;
    logic              adv2;
    logic [FW-1:0]     quot_full;
    logic [slbm_pkg::LEVEL_W:0] quot;
    logic [slbm_pkg::LEVEL_W:0] level_sum;
    slbm_pkg::level_t  level_next;

    // Only one block in the update loop, so stage A always sees a settled level
    assign in_ready = !vld2_reg;
    assign in_xfer  = in_valid && in_ready;
    assign adv2     = vld2_reg && (!vld3_reg || out_ready);

    // new = level + floor(p * (avg - level) / 100); a negative step rounds its magnitude up
    assign neg_a  = (in_avg < level_reg);
    assign diff_a = neg_a ? (level_reg - in_avg) : (in_avg - level_reg);
    assign prod_a = PW'(pct) * PW'(diff_a);
    assign mag_a  = neg_a ? (prod_a + slbm_pkg::DIV100_ROUND) : prod_a;

    // Divide by 100 through the reciprocal and apply the step
    assign quot_full = FW'(mag2_reg) * FW'(slbm_pkg::DIV100_MUL);
    assign quot      = quot_full[slbm_pkg::DIV100_SHIFT +: (slbm_pkg::LEVEL_W + 1)];
    assign level_sum = neg2_reg ? ({1'b0, level_reg} - quot) : ({1'b0, level_reg} + quot);
    assign level_next = level_sum[slbm_pkg::LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            vld2_reg  <= 1'b0;
            vld3_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                vld2_reg <= 1'b1;
            end
            else if (adv2)
            begin
                vld2_reg <= 1'b0;
            end

            if (adv2)
            begin
                level_reg <= level_next;
                vld3_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                vld3_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            neg2_reg <= neg_a;
            mag2_reg <= mag_a;
            avg2_reg <= in_avg;
        end
        if (adv2)
        begin
            lvl3_reg.level <= level_next;
            lvl3_reg.avg   <= avg2_reg;
        end
    end

    assign out_valid = vld3_reg;
    assign out_lvl   = lvl3_reg;

    // Level state moves only when a stage A result passes on
    a_level_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(level_reg) |-> $past(adv2))
        else $error("level changed without an update");

    // A waiting update result keeps its contents
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg && !out_ready |=> vld3_reg && $stable(lvl3_reg))
        else $error("stalled level result changed");

    // The result copy matches the level state when it is loaded
    a_copy_match: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 |=> lvl3_reg.level == level_reg)
        else $error("level copy differs from state");

endmodule

`default_nettype wire

FILE: hdl/slbm_color.sv
`timescale 1ns / 1ps
`default_nettype none

module slbm_color #(
    parameter int LED_COUNT = 16
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire slbm_pkg::lvl_t   in_lvl,
    output logic                  out_valid,
    input  wire                   out_ready,
    output slbm_pkg::res_t        out_res
);

    localparam int LW = slbm_pkg::LEVEL_W + $clog2(LED_COUNT + 1);

    typedef enum logic [1:0] {
        BAND_RISE,
        BAND_HIGH,
        BAND_LOW,
        BAND_TOP
    } band_t;

    logic              vld_reg;
    slbm_pkg::res_t    res_reg;

    logic [LW-1:0]     lit_prod;
    logic [LW-1:0]     lit_raw;
    logic [LW-1:0]     lit_clamp;
    band_t             band;
    logic [5:0]        step;
    logic [slbm_pkg::COLOR_W-1:0] red;
    logic [slbm_pkg::COLOR_W-1:0] green;
    logic              in_xfer;

    assign in_ready = !vld_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Lit LED count: level * LED_COUNT / 256, clamped
    assign lit_prod  = LW'(in_lvl.level) * LW'(LED_COUNT);
    assign lit_raw   = lit_prod >> 8;
    assign lit_clamp = (lit_raw > LW'(LED_COUNT)) ? LW'(LED_COUNT) : lit_raw;

    // Color band from the level; 192 and up is solid red
    assign step = in_lvl.level[5:0];
    always_comb
    begin
        if (in_lvl.level[9:8] != 2'b00)
        begin
            band = BAND_TOP;
        end
        else
        begin
            band = band_t'(in_lvl.level[7:6]);
        end
    end

    always_comb
    begin
        unique case (band)
            BAND_RISE:
            begin
                red   = slbm_pkg::RED_RAMP[step];
                green = slbm_pkg::COLOR_FULL;
            end
            BAND_HIGH:
            begin
                red   = slbm_pkg::COLOR_FULL;
                green = slbm_pkg::GRN_HI[step];
            end
            BAND_LOW:
            begin
                red   = slbm_pkg::COLOR_FULL;
                green = slbm_pkg::GRN_LO[step];
            end
            default:
            begin
                red   = slbm_pkg::COLOR_FULL;
                green = slbm_pkg::COLOR_OFF;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg.avg   <= in_lvl.avg;
            res_reg.level <= in_lvl.level;
            res_reg.lit   <= slbm_pkg::LIT_W'(lit_clamp);
            res_reg.red   <= red;
            res_reg.green <= green;
            res_reg.blue  <= slbm_pkg::COLOR_OFF;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    // Green below full only once red is saturated
    a_color_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && (res_reg.green != slbm_pkg::COLOR_FULL) |-> res_reg.red == slbm_pkg::COLOR_FULL)
        else $error("green dropped before red reached full");

endmodule

`default_nettype wire
